[sv/cglu_pkg.sv]
`default_nettype none
package cglu_pkg;

  localparam int unsigned POS_W = 17;
  localparam int unsigned FRAC_W = 16;
  localparam int unsigned MUL_B_W = 10;
  localparam int unsigned PROD_W = POS_W + 1 + MUL_B_W;
  localparam logic [7:0] ALPHA_OPAQUE = 8'hff;

  typedef enum logic {
    OP_APPEND = 1'b0,
    OP_LOOKUP = 1'b1
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_WHOLE,
    S_INDEX,
    S_READ_HI,
    S_RED,
    S_GREEN,
    S_BLUE,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic              operation;
    logic [31:0]       stop_color;
    logic [POS_W-1:0]  position;
  } item_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } result_t;

  // Signed difference of two channel values, the slope of one segment.
  function automatic logic signed [MUL_B_W-1:0] chan_diff(input logic [7:0] hi,
                                                         input logic [7:0] lo);
    logic signed [MUL_B_W-1:0] h;
    logic signed [MUL_B_W-1:0] l;
    h = signed'({2'b00, hi});
    l = signed'({2'b00, lo});
    return h - l;
  endfunction

  // lo*65536 + f*(hi-lo) equals f*hi + (65536-f)*lo, truncated once.
  function automatic logic [7:0] blend_chan(input logic [7:0] lo,
                                            input logic signed [PROD_W-1:0] prod);
    logic signed [PROD_W-1:0] base;
    logic signed [PROD_W-1:0] sum;
    base = signed'({{(PROD_W-24){1'b0}}, lo, 16'h0000});
    sum = base + prod;
    return sum[23:16];
  endfunction

endpackage
`default_nettype wire

[sv/cglu_mul.sv]
`default_nettype none
module cglu_mul (
  input  wire logic                                 clk,
  input  wire logic [cglu_pkg::POS_W-1:0]           a,
  input  wire logic signed [cglu_pkg::MUL_B_W-1:0]  b,
  output logic signed [cglu_pkg::PROD_W-1:0]        prod
);
  import cglu_pkg::*;

  logic signed [POS_W:0] a_s;

  assign a_s = signed'({1'b0, a});

  always_ff @(posedge clk) begin
    prod <= a_s * b;
  end

endmodule
`default_nettype wire

[sv/cglu_table.sv]
`default_nettype none
module cglu_table #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW = 4
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [31:0]   wdata,
  input  wire logic [AW-1:0] raddr,
  output logic [31:0]        rdata
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[sv/color_gradient_lookup_unit.sv]
`default_nettype none
// Channel   | Direction | Handshake                     | Payload
// item      | in        | start high while busy low     | item_t: operation, stop_color, position
// result    | out       | done high for one cycle       | result_t: red, green, blue, alpha
// config    | in        | APB write, psel&penable&pwrite | pwdata[0] to wrap_mode when paddr[2] is 0
//
// An append writes the stop table at the accepting edge. A lookup on an empty table
// ends in S_DECIDE, one that returns a stop whole runs S_DECIDE and S_WHOLE, and an
// interpolated lookup runs S_DECIDE, S_INDEX, S_READ_HI, S_RED, S_GREEN, S_BLUE and
// S_FINISH: the index scaling and the three channel blends share one multiplier, and
// the two stops come through the single registered read port of the table.
// rst is synchronous and clears the sequencer, the stop count and wrap_mode.
// The receiver cannot stall: a result is on the ports with done and holds until the next lookup's S_DECIDE.
module color_gradient_lookup_unit #(
  parameter int unsigned MAX_COLORS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire cglu_pkg::item_t   item,
  output logic                   done,
  output cglu_pkg::result_t      result,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [2:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);
  import cglu_pkg::*;

  localparam int unsigned CW = $clog2(MAX_COLORS + 1);
  localparam int unsigned IW = (MAX_COLORS > 1) ? $clog2(MAX_COLORS) : 1;
  localparam int unsigned LO_W = PROD_W - 1 - FRAC_W;

  state_t state, state_next;

  logic                       wrap_mode;
  logic [CW-1:0]              stop_count;
  logic [POS_W-1:0]           pos_q;
  logic [31:0]                lo_color;
  logic [31:0]                hi_color;
  logic [FRAC_W-1:0]          f_q;
  logic [IW-1:0]              lo_idx;
  logic [7:0]                 red_q;
  logic [7:0]                 green_q;

  logic                       accept;
  logic                       cfg_write;
  logic                       tbl_we;
  logic [IW-1:0]              tbl_raddr;
  logic [31:0]                tbl_rdata;
  logic [POS_W-1:0]           mul_a;
  logic signed [MUL_B_W-1:0]  mul_b;
  logic signed [PROD_W-1:0]   prod;

  logic [CW-1:0]              last_stop;
  logic [CW-1:0]              seg_count;
  logic                       whole;
  logic [IW-1:0]              whole_addr;
  logic [LO_W-1:0]            lo_full;
  logic [CW-1:0]              lo_sel;
  logic [CW-1:0]              hi_inc;
  logic [IW-1:0]              hi_idx;
  logic [31:0]                hi_src;

  assign accept    = start && !busy;
  assign busy      = (state != S_IDLE);
  assign cfg_write = psel && penable && pwrite && pready;
  assign pready    = 1'b1;
  assign prdata    = (paddr[2] == 1'b0) ? {31'd0, wrap_mode} : 32'd0;
  assign tbl_we    = accept && (item.operation == OP_APPEND) &&
                     (stop_count < CW'(MAX_COLORS));

  assign last_stop  = stop_count - CW'(1);
  assign seg_count  = wrap_mode ? stop_count : last_stop;
  assign whole      = (stop_count == CW'(1)) || (pos_q == '0) || pos_q[POS_W-1];
  assign whole_addr = (pos_q[POS_W-1] && !wrap_mode && (stop_count != CW'(1)) &&
                       (pos_q != '0)) ? last_stop[IW-1:0] : '0;

  assign lo_full = prod[PROD_W-2:FRAC_W];
  assign lo_sel  = (lo_full >= LO_W'(stop_count)) ? last_stop : lo_full[CW-1:0];
  assign hi_inc  = CW'(lo_idx) + CW'(1);
  assign hi_idx  = (hi_inc >= stop_count) ? '0 : hi_inc[IW-1:0];
  assign hi_src  = (state == S_RED) ? tbl_rdata : hi_color;

  cglu_table #(
    .DEPTH (MAX_COLORS),
    .AW    (IW)
  ) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (stop_count[IW-1:0]),
    .wdata (item.stop_color),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  cglu_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && (item.operation == OP_LOOKUP)) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (stop_count == '0) begin
          state_next = S_IDLE;
        end else if (whole) begin
          state_next = S_WHOLE;
        end else begin
          state_next = S_INDEX;
        end
      end
      S_WHOLE:   state_next = S_IDLE;
      S_INDEX:   state_next = S_READ_HI;
      S_READ_HI: state_next = S_RED;
      S_RED:     state_next = S_GREEN;
      S_GREEN:   state_next = S_BLUE;
      S_BLUE:    state_next = S_FINISH;
      S_FINISH:  state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // Read address and multiplier operands for each step of the sequence.
  always_comb begin
    tbl_raddr = '0;
    mul_a     = '0;
    mul_b     = '0;
    unique case (state)
      S_DECIDE: begin
        tbl_raddr = whole_addr;
        mul_a     = pos_q;
        mul_b     = signed'(MUL_B_W'(seg_count));
      end
      S_INDEX: begin
        tbl_raddr = lo_sel[IW-1:0];
      end
      S_READ_HI: begin
        tbl_raddr = hi_idx;
      end
      S_RED: begin
        mul_a = {1'b0, f_q};
        mul_b = chan_diff(hi_src[23:16], lo_color[23:16]);
      end
      S_GREEN: begin
        mul_a = {1'b0, f_q};
        mul_b = chan_diff(hi_src[15:8], lo_color[15:8]);
      end
      S_BLUE: begin
        mul_a = {1'b0, f_q};
        mul_b = chan_diff(hi_src[7:0], lo_color[7:0]);
      end
      default: begin
        tbl_raddr = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      stop_count <= '0;
      wrap_mode  <= 1'b0;
      done       <= 1'b0;
    end else begin
      state <= state_next;
      if (tbl_we) begin
        stop_count <= stop_count + CW'(1);
      end
      if (cfg_write && (paddr[2] == 1'b0)) begin
        wrap_mode <= pwdata[0];
      end
      done <= ((state == S_DECIDE) && (stop_count == '0)) ||
              (state == S_WHOLE) || (state == S_FINISH);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pos_q <= item.position;
    end
    unique case (state)
      S_DECIDE: begin
        result <= '{red: 8'd0, green: 8'd0, blue: 8'd0, alpha: ALPHA_OPAQUE};
      end
      S_WHOLE: begin
        result <= '{red: tbl_rdata[23:16], green: tbl_rdata[15:8],
                    blue: tbl_rdata[7:0], alpha: tbl_rdata[31:24]};
      end
      S_INDEX: begin
        lo_idx <= lo_sel[IW-1:0];
        f_q    <= prod[FRAC_W-1:0];
      end
      S_READ_HI: begin
        lo_color <= tbl_rdata;
      end
      S_RED: begin
        hi_color <= tbl_rdata;
      end
      S_GREEN: begin
        red_q <= blend_chan(lo_color[23:16], prod);
      end
      S_BLUE: begin
        green_q <= blend_chan(lo_color[15:8], prod);
      end
      S_FINISH: begin
        result <= '{red: red_q, green: green_q,
                    blue: blend_chan(lo_color[7:0], prod), alpha: ALPHA_OPAQUE};
      end
      default: begin
        lo_idx <= lo_idx;
      end
    endcase
  end

  a_done_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past((state == S_FINISH) || (state == S_WHOLE) ||
                   ((state == S_DECIDE) && (stop_count == '0))))
    else $error("done raised without a finished lookup");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    stop_count <= CW'(MAX_COLORS))
    else $error("stop count beyond table depth");

  a_count_change: assert property (@(posedge clk) disable iff (rst)
    (stop_count != $past(stop_count)) |-> $past(tbl_we))
    else $error("stop count changed without an append");

  a_index_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_INDEX) |-> $past(state == S_DECIDE))
    else $error("index step entered out of order");

  a_no_append_busy: assert property (@(posedge clk) disable iff (rst)
    tbl_we |-> (state == S_IDLE))
    else $error("table written while a lookup is in flight");

endmodule
`default_nettype wire
